@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, checked out of reset
`define GCD_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("gcd assertion failed");

// implication in the next cycle, checked out of reset
`define GCD_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("gcd assertion failed");

`endif

@@ rtl/core/gcd_pkg.sv @@
`timescale 1ns / 1ps

package gcd_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 32;

    // q1.30 sine, cosine and products
    localparam int QW  = 32;
    // rotation datapath and angle accumulator
    localparam int RW  = 34;
    localparam int RZW = 34;
    // atan2 arguments, vectoring datapath and angle accumulator
    localparam int AW  = 33;
    localparam int VW  = 36;
    localparam int VZW = 34;
    localparam int SW  = 64;

    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic signed [RW-1:0] ROT_GAIN = RW'(652032874);
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // atan(2^-i) in binary-angle units
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    function automatic logic signed [QW-1:0] mulq(
        input logic signed [QW-1:0] a,
        input logic signed [QW-1:0] b
    );
        logic signed [2*QW-1:0] p;
        p = a * b;
        return p[QW+29:30];
    endfunction

endpackage

@@ rtl/core/great_circle_distance_and_azimuths.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   handshake                 payload
// input     in_valid / in_stall       start_lat, start_lon, end_lat, end_lon
// output    out_valid / out_stall     arc_angle, forward_azimuth, reverse_azimuth
//
// one item per cycle while out_stall does not hold the pipe; the sine/cosine cordic,
// the 32-step root and the atan2 cordic run in series
// the whole pipe moves on one enable; a held output stalls every stage and the input
// in_stall is high exactly while a finished item waits under out_stall
// reset clears the valid bits only; no state survives between items

module great_circle_distance_and_azimuths
    import gcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] start_lat,
    input  logic signed [31:0] start_lon,
    input  logic signed [31:0] end_lat,
    input  logic signed [31:0] end_lon,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        arc_angle,
    output logic [31:0]        forward_azimuth,
    output logic [31:0]        reverse_azimuth
);

    logic en;

    logic        f_vld_reg;
    logic [31:0] ang_b1_reg, ang_b2_reg, ang_hdb_reg, ang_dl_reg, ang_hdl_reg;
    logic [32:0] diff_b, diff_l;

    logic                 rot_vld;
    logic signed [QW-1:0] sb1, cb1, sb2, cb2, sdb2, sdl, cdl, sdl2;

    logic                 m1_vld_reg;
    logic signed [QW-1:0] c12_reg, p1_reg, q_reg, y1_reg, t1_reg, u1_reg;
    logic signed [QW-1:0] y2_reg, t2_reg, u2_reg, cdl_reg;

    logic                 m2_vld_reg;
    logic signed [QW-1:0] r_reg, v1_reg, v2_reg, p1b_reg, y1b_reg, t1b_reg;
    logic signed [QW-1:0] y2b_reg, t2b_reg;

    logic                 m3_vld_reg;
    logic [30:0]          a_reg, b_reg;
    logic signed [AW-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [AW-1:0] hav_sum;
    logic [30:0]          a_sat;

    logic signed [AW-1:0] dx1_reg [SQRT_STEPS];
    logic signed [AW-1:0] dy1_reg [SQRT_STEPS];
    logic signed [AW-1:0] dx2_reg [SQRT_STEPS];
    logic signed [AW-1:0] dy2_reg [SQRT_STEPS];

    logic        sq_vld;
    logic [31:0] ra, rb;

    logic        v_vld;
    logic [31:0] half, faz, raz;

    logic        out_valid_reg;
    logic [31:0] arc_reg, faz_reg, raz_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // front: the five angles that need a sine or cosine
    assign diff_b = {start_lat[31], start_lat} - {end_lat[31], end_lat};
    assign diff_l = {end_lon[31], end_lon} - {start_lon[31], start_lon};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_b1_reg  <= start_lat;
            ang_b2_reg  <= end_lat;
            ang_hdb_reg <= diff_b[32:1];
            ang_dl_reg  <= diff_l[31:0];
            ang_hdl_reg <= diff_l[32:1];
        end
    end

    gcd_rot u_rot_b1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_reg), .in_ang(ang_b1_reg),
        .out_vld(rot_vld), .out_sin(sb1), .out_cos(cb1)
    );

    gcd_rot u_rot_b2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_reg), .in_ang(ang_b2_reg),
        .out_vld(), .out_sin(sb2), .out_cos(cb2)
    );

    gcd_rot u_rot_hdb (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_reg), .in_ang(ang_hdb_reg),
        .out_vld(), .out_sin(sdb2), .out_cos()
    );

    gcd_rot u_rot_dl (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_reg), .in_ang(ang_dl_reg),
        .out_vld(), .out_sin(sdl), .out_cos(cdl)
    );

    gcd_rot u_rot_hdl (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_reg), .in_ang(ang_hdl_reg),
        .out_vld(), .out_sin(sdl2), .out_cos()
    );

    // products, one multiplier deep per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= rot_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c12_reg <= mulq(cb1, cb2);
            p1_reg  <= mulq(sdb2, sdb2);
            q_reg   <= mulq(sdl2, sdl2);
            y1_reg  <= mulq(cb2, sdl);
            t1_reg  <= mulq(cb1, sb2);
            u1_reg  <= mulq(sb1, cb2);
            y2_reg  <= mulq(cb1, sdl);
            t2_reg  <= mulq(cb2, sb1);
            u2_reg  <= mulq(sb2, cb1);
            cdl_reg <= cdl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= mulq(c12_reg, q_reg);
            v1_reg  <= mulq(u1_reg, cdl_reg);
            v2_reg  <= mulq(u2_reg, cdl_reg);
            p1b_reg <= p1_reg;
            y1b_reg <= y1_reg;
            t1b_reg <= t1_reg;
            y2b_reg <= y2_reg;
            t2b_reg <= t2_reg;
        end
    end

    // haversine term, clamped to 0..1
    assign hav_sum = AW'(p1b_reg) + AW'(r_reg);

    always_comb
    begin
        if (hav_sum < 0)
        begin
            a_sat = '0;
        end
        else if (hav_sum > signed'(AW'(ONE_Q30)))
        begin
            a_sat = ONE_Q30;
        end
        else
        begin
            a_sat = hav_sum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_sat;
            b_reg   <= ONE_Q30 - a_sat;
            ay1_reg <= AW'(y1b_reg);
            ax1_reg <= AW'(t1b_reg) - AW'(v1_reg);
            ay2_reg <= -AW'(y2b_reg);
            ax2_reg <= AW'(t2b_reg) - AW'(v2_reg);
        end
    end

    gcd_sqrt u_sqrt_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m3_vld_reg), .in_val(a_reg),
        .out_vld(sq_vld), .out_root(ra)
    );

    gcd_sqrt u_sqrt_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m3_vld_reg), .in_val(b_reg),
        .out_vld(), .out_root(rb)
    );

    // azimuth arguments wait alongside the roots
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (k == 0)
                begin
                    dx1_reg[k] <= ax1_reg;
                    dy1_reg[k] <= ay1_reg;
                    dx2_reg[k] <= ax2_reg;
                    dy2_reg[k] <= ay2_reg;
                end
                else
                begin
                    dx1_reg[k] <= dx1_reg[(k > 0) ? k - 1 : 0];
                    dy1_reg[k] <= dy1_reg[(k > 0) ? k - 1 : 0];
                    dx2_reg[k] <= dx2_reg[(k > 0) ? k - 1 : 0];
                    dy2_reg[k] <= dy2_reg[(k > 0) ? k - 1 : 0];
                end
            end
        end
    end

    gcd_vec u_vec_arc (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(sq_vld),
        .in_y(AW'(ra)), .in_x(AW'(rb)),
        .out_vld(v_vld), .out_ang(half)
    );

    gcd_vec u_vec_fwd (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(sq_vld),
        .in_y(dy1_reg[SQRT_STEPS-1]), .in_x(dx1_reg[SQRT_STEPS-1]),
        .out_vld(), .out_ang(faz)
    );

    gcd_vec u_vec_rev (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(sq_vld),
        .in_y(dy2_reg[SQRT_STEPS-1]), .in_x(dx2_reg[SQRT_STEPS-1]),
        .out_vld(), .out_ang(raz)
    );

    // output register; half angle doubled, slightly negative reads as zero, a quarter turn or more as a half turn
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (half > HALF_TURN)
            begin
                arc_reg <= '0;
            end
            else if (half >= QUARTER_TURN)
            begin
                arc_reg <= HALF_TURN;
            end
            else
            begin
                arc_reg <= {half[30:0], 1'b0};
            end
            faz_reg <= faz;
            raz_reg <= raz;
        end
    end

    assign out_valid       = out_valid_reg;
    assign arc_angle       = arc_reg;
    assign forward_azimuth = faz_reg;
    assign reverse_azimuth = raz_reg;

    `GCD_ASSERT_IMP(a_arc_max, out_valid, arc_angle <= HALF_TURN)
    `GCD_ASSERT_IMP(a_hav_split, m3_vld_reg, (a_reg <= ONE_Q30) && (b_reg <= ONE_Q30))
    `GCD_ASSERT_NXT(a_hold_out, out_valid_reg && out_stall, out_valid_reg)

endmodule

@@ rtl/core/gcd_rot.sv @@
`timescale 1ns / 1ps

module gcd_rot
    import gcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [31:0]          in_ang,
    output logic                 out_vld,
    output logic signed [QW-1:0] out_sin,
    output logic signed [QW-1:0] out_cos
);

    logic signed [RW-1:0]  x_reg [CORDIC_STAGES];
    logic signed [RW-1:0]  y_reg [CORDIC_STAGES];
    logic signed [RZW-1:0] z_reg [CORDIC_STAGES];
    logic                  flip_reg [CORDIC_STAGES];
    logic                  vld_reg [CORDIC_STAGES];

    logic signed [RW-1:0]  x_in [CORDIC_STAGES];
    logic signed [RW-1:0]  y_in [CORDIC_STAGES];
    logic signed [RZW-1:0] z_in [CORDIC_STAGES];
    logic                  flip_in [CORDIC_STAGES];
    logic                  vld_in [CORDIC_STAGES];

    logic        flip;
    logic [31:0] u;

    // fold the left half plane onto the right by half a turn
    assign flip = in_ang[31] ^ in_ang[30];
    assign u    = {in_ang[31] ^ flip, in_ang[30:0]};

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [RW-1:0]  dx;
        logic signed [RW-1:0]  dy;
        logic signed [RZW-1:0] step;

        if (i == 0)
        begin : g_first
            assign x_in[i]    = ROT_GAIN;
            assign y_in[i]    = '0;
            assign z_in[i]    = {{(RZW-32){u[31]}}, u};
            assign flip_in[i] = flip;
            assign vld_in[i]  = in_vld;
        end
        else
        begin : g_next
            assign x_in[i]    = x_reg[i-1];
            assign y_in[i]    = y_reg[i-1];
            assign z_in[i]    = z_reg[i-1];
            assign flip_in[i] = flip_reg[i-1];
            assign vld_in[i]  = vld_reg[i-1];
        end

        assign dx   = y_in[i] >>> i;
        assign dy   = x_in[i] >>> i;
        assign step = RZW'(ATAN_TAB[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i] <= flip_in[i];
                if (z_in[i] >= 0)
                begin
                    x_reg[i] <= x_in[i] - dx;
                    y_reg[i] <= y_in[i] + dy;
                    z_reg[i] <= z_in[i] - step;
                end
                else
                begin
                    x_reg[i] <= x_in[i] + dx;
                    y_reg[i] <= y_in[i] - dy;
                    z_reg[i] <= z_in[i] + step;
                end
            end
        end
    end

    assign out_vld = vld_reg[CORDIC_STAGES-1];
    assign out_sin = QW'(flip_reg[CORDIC_STAGES-1] ? -y_reg[CORDIC_STAGES-1]
                                                   : y_reg[CORDIC_STAGES-1]);
    assign out_cos = QW'(flip_reg[CORDIC_STAGES-1] ? -x_reg[CORDIC_STAGES-1]
                                                   : x_reg[CORDIC_STAGES-1]);

endmodule

@@ rtl/core/gcd_vec.sv @@
`timescale 1ns / 1ps

module gcd_vec
    import gcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic signed [AW-1:0] in_y,
    input  logic signed [AW-1:0] in_x,
    output logic                 out_vld,
    output logic [31:0]          out_ang
);

    logic signed [VW-1:0]  x_reg [CORDIC_STAGES];
    logic signed [VW-1:0]  y_reg [CORDIC_STAGES];
    logic signed [VZW-1:0] z_reg [CORDIC_STAGES];
    logic                  zero_reg [CORDIC_STAGES];
    logic                  vld_reg [CORDIC_STAGES];

    logic signed [VW-1:0]  x_in [CORDIC_STAGES];
    logic signed [VW-1:0]  y_in [CORDIC_STAGES];
    logic signed [VZW-1:0] z_in [CORDIC_STAGES];
    logic                  zero_in [CORDIC_STAGES];
    logic                  vld_in [CORDIC_STAGES];

    logic signed [VW-1:0] ext_x;
    logic signed [VW-1:0] ext_y;
    logic                 neg;

    assign ext_x = VW'(in_x);
    assign ext_y = VW'(in_y);
    assign neg   = in_x[AW-1];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [VW-1:0]  dx;
        logic signed [VW-1:0]  dy;
        logic signed [VZW-1:0] step;

        if (i == 0)
        begin : g_first
            // left half plane: turn the vector by half a turn first
            assign x_in[i]    = neg ? -ext_x : ext_x;
            assign y_in[i]    = neg ? -ext_y : ext_y;
            assign z_in[i]    = neg ? VZW'(HALF_TURN) : '0;
            assign zero_in[i] = (in_x == '0) && (in_y == '0);
            assign vld_in[i]  = in_vld;
        end
        else
        begin : g_next
            assign x_in[i]    = x_reg[i-1];
            assign y_in[i]    = y_reg[i-1];
            assign z_in[i]    = z_reg[i-1];
            assign zero_in[i] = zero_reg[i-1];
            assign vld_in[i]  = vld_reg[i-1];
        end

        assign dx   = y_in[i] >>> i;
        assign dy   = x_in[i] >>> i;
        assign step = VZW'(ATAN_TAB[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i] <= zero_in[i];
                if (y_in[i] >= 0)
                begin
                    x_reg[i] <= x_in[i] + dx;
                    y_reg[i] <= y_in[i] - dy;
                    z_reg[i] <= z_in[i] + step;
                end
                else
                begin
                    x_reg[i] <= x_in[i] - dx;
                    y_reg[i] <= y_in[i] + dy;
                    z_reg[i] <= z_in[i] - step;
                end
            end
        end
    end

    assign out_vld = vld_reg[CORDIC_STAGES-1];
    assign out_ang = zero_reg[CORDIC_STAGES-1] ? '0 : z_reg[CORDIC_STAGES-1][31:0];

endmodule

@@ rtl/core/gcd_sqrt.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcd_sqrt
    import gcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [30:0] in_val,
    output logic        out_vld,
    output logic [31:0] out_root
);

    logic [SW-1:0] n_reg [SQRT_STEPS];
    logic [SW-1:0] res_reg [SQRT_STEPS];
    logic          vld_reg [SQRT_STEPS];

    logic [SW-1:0] n_in [SQRT_STEPS];
    logic [SW-1:0] res_in [SQRT_STEPS];
    logic          vld_in [SQRT_STEPS];

    // one result bit per stage, restoring
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [SW-1:0] BITV = SW'(1) << (2 * SQRT_STEPS - 2 - 2 * k);
        logic [SW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign n_in[k]   = SW'(in_val) << 30;
            assign res_in[k] = '0;
            assign vld_in[k] = in_vld;
        end
        else
        begin : g_next
            assign n_in[k]   = n_reg[k-1];
            assign res_in[k] = res_reg[k-1];
            assign vld_in[k] = vld_reg[k-1];
        end

        assign trial = res_in[k] + BITV;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_in[k] >= trial)
                begin
                    n_reg[k]   <= n_in[k] - trial;
                    res_reg[k] <= (res_in[k] >> 1) + BITV;
                end
                else
                begin
                    n_reg[k]   <= n_in[k];
                    res_reg[k] <= res_in[k] >> 1;
                end
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS-1];
    assign out_root = res_reg[SQRT_STEPS-1][31:0];

    // input never exceeds one in q1.30, so neither may its root
    `GCD_ASSERT_IMP(a_root_max, out_vld, out_root <= QUARTER_TURN)

endmodule
